// File: rtl/mm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and codes of the matrix multiply block: word formats of the
// input and result channels, item modes and register indexes.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 69;  // exact sum of up to 16 full products
    localparam int DIM_W     = 5;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] MODE_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] MODE_COMPUTE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
    } mm_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [DATA_W-1:0] product;
        logic                    last;
    } mm_out_t;

endpackage
`default_nettype wire

// File: rtl/mm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/matrix_multiply_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_top
// Fixed point matrix multiplier: left and right element stores, one shared
// multiply-accumulate unit, one product row emitted per compute word whose row is in range.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid / in_stall / in_word): load words write one element
//     of the left or right store; a compute word names a product row.
//   out channel (out_valid / out_stall / out_word): one word per product
//     column in column order, last set on the final column.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): left_rows,
//     inner_size, right_cols; cfg_ready is always high, values are clamped
//     to 1..min(MAX_DIM,16). Write only while the block is idle.
// Operation:
//   a load word is taken whenever the block is idle. A compute word holds
//   in_stall high until the row is done: per column, inner_size element
//   reads on the two store read ports feed the single 32x32 multiplier,
//   then the multiply / accumulate registers drain and the sum is rounded,
//   saturated and loaded into the output register.
// Reset: registers return to 16 (clamped), nothing is in flight. Store
//   contents are undefined until written; no clearing pass is run.
// Stall: a finished column waits in the output register; the next column's
//   sums run meanwhile and wait at rounding until the register frees up.
// ----------------------------------------------------------------------------
module matrix_multiply_top #(
    parameter int MAX_DIM   = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire mm_pkg::mm_in_t                in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output mm_pkg::mm_out_t                    out_word,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mm_pkg::DIM_W-1:0]      cfg_data
);

    import mm_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);
    localparam int HALF_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic signed [ACC_W:0] HALF =
        (FRAC_BITS > 0) ? ((ACC_W + 1)'(1) << HALF_SH) : '0;
    localparam logic signed [ACC_W:0] SAT_MAX = {{(ACC_W - 30){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W:0] SAT_MIN = {{(ACC_W - 30){1'b1}}, {31{1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t             state_reg;
    logic [DIM_W-1:0]   left_rows_reg;
    logic [DIM_W-1:0]   inner_reg;
    logic [DIM_W-1:0]   cols_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   c_reg;
    logic               rd_vld_reg;
    logic               prod_vld_reg;
    logic               out_valid_reg;
    mm_out_t            out_word_reg;

    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic               in_accept;
    logic               load_ok;
    logic               row_ok;
    logic               we_left;
    logic               we_right;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      left_raddr;
    logic [AW-1:0]      right_raddr;
    logic               rd_en;
    logic [DATA_W-1:0]  left_rdata;
    logic [DATA_W-1:0]  right_rdata;
    logic [DIM_W-1:0]   cfg_clamped;
    logic               out_free;
    logic               pipe_empty;
    logic               emit;
    logic               acc_clr;
    logic               last_k;
    logic               last_c;
    logic signed [ACC_W:0]    rounded;
    logic signed [ACC_W:0]    shifted;
    logic signed [DATA_W-1:0] sat_value;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign load_ok  = (32'(in_word.row) < MAX_DIM) && (32'(in_word.col) < MAX_DIM);
    assign row_ok   = ({1'b0, in_word.row} < left_rows_reg)
                   && ({1'b0, in_word.row} < DIM_CAP_V);
    assign we_left  = in_accept && (in_word.mode == MODE_LOAD_LEFT) && load_ok;
    assign we_right = in_accept && (in_word.mode == MODE_LOAD_RIGHT) && load_ok;
    assign waddr    = AW'(32'(in_word.row) * MAX_DIM + 32'(in_word.col));

    assign rd_en       = (state_reg == S_RUN);
    assign left_raddr  = AW'(32'(row_reg) * MAX_DIM + 32'(k_reg));
    assign right_raddr = AW'(32'(k_reg) * MAX_DIM + 32'(c_reg));

    assign last_k     = (k_reg == IDX_W'(inner_reg - DIM_W'(1)));
    assign last_c     = (c_reg == IDX_W'(cols_reg - DIM_W'(1)));
    assign out_free   = !out_valid_reg || !out_stall;
    assign pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign emit       = (state_reg == S_DRAIN) && pipe_empty && out_free;
    assign acc_clr    = emit || (in_accept && (in_word.mode == MODE_COMPUTE));

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = DIM_W'(1);
        end
        else if (cfg_data > DIM_CAP_V)
        begin
            cfg_clamped = DIM_CAP_V;
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // round to nearest with ties up, then saturate to 32 bits
    always_comb
    begin
        rounded = (ACC_W + 1)'(acc_reg) + HALF;
        shifted = rounded >>> FRAC_BITS;
        if (shifted > SAT_MAX)
        begin
            sat_value = DATA_W'(SAT_MAX);
        end
        else if (shifted < SAT_MIN)
        begin
            sat_value = DATA_W'(SAT_MIN);
        end
        else
        begin
            sat_value = DATA_W'(shifted);
        end
    end

    mm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (we_left),
        .waddr (waddr),
        .wdata (in_word.value),
        .re    (rd_en),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    mm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (we_right),
        .waddr (waddr),
        .wdata (in_word.value),
        .re    (rd_en),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    // shared multiply-accumulate unit
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= $signed(left_rdata) * $signed(right_rdata);
        end
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_rows_reg <= DIM_CAP_V;
            inner_reg     <= DIM_CAP_V;
            cols_reg      <= DIM_CAP_V;
            row_reg       <= '0;
            k_reg         <= '0;
            c_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LEFT_ROWS:  left_rows_reg <= cfg_clamped;
                    CFG_INNER_SIZE: inner_reg     <= cfg_clamped;
                    CFG_RIGHT_COLS: cols_reg      <= cfg_clamped;
                    default:        ;
                endcase
            end

            rd_vld_reg   <= rd_en;
            prod_vld_reg <= rd_vld_reg;

            if (out_valid_reg && !out_stall && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (in_word.mode == MODE_COMPUTE) && row_ok)
                    begin
                        row_reg   <= in_word.row;
                        k_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (last_k)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + IDX_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (emit)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_word_reg.out_row <= row_reg;
                        out_word_reg.out_col <= c_reg;
                        out_word_reg.product <= sat_value;
                        out_word_reg.last    <= last_c;
                        k_reg                <= '0;
                        if (last_c)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            c_reg     <= c_reg + IDX_W'(1);
                            state_reg <= S_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a new word only lands in the output register after the sums have drained
    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DRAIN && pipe_empty))
        else $error("result loaded before accumulation finished");

    // input is only taken with the multiply-accumulate pipe empty
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> pipe_empty)
        else $error("input accepted while products still in flight");

    // the term counter never runs past the inner size
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> ({1'b0, k_reg} < inner_reg))
        else $error("term index beyond inner size");

    // a product is only formed from data read in the cycle before
    a_prod_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> $past(rd_vld_reg))
        else $error("product valid without a preceding read");

    // a row ends with the last flag and returns to idle
    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_c |=> (state_reg == S_IDLE) && out_word_reg.last)
        else $error("row did not end on its last column");

endmodule
`default_nettype wire
